// ----- hdl/cfwrl_pkg.sv -----
// Shared types, constants and reset values of the client fixed-window rate limiter.
package cfwrl_pkg;

  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned TALLY_W       = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned IN_TDATA_W    = 40;
  localparam int unsigned OUT_TDATA_W   = 32;
  localparam int unsigned DEF_CLIENT_SLOTS = 64;

  localparam logic [TICK_W-1:0]  RST_WINDOW_TICKS = 32'd60000;
  localparam logic [TALLY_W-1:0] RST_REQUEST_CAP  = 16'd120;
  localparam logic [TALLY_W-1:0] RST_TOOL_CAP     = 16'd60;
  localparam logic [TALLY_W-1:0] TALLY_MAX        = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_TICKS = 2'd0,
    REG_REQUEST_CAP  = 2'd1,
    REG_TOOL_CAP     = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TICK_W-1:0]  window_ticks;
    logic [TALLY_W-1:0] request_cap;
    logic [TALLY_W-1:0] tool_cap;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0]  window_begin;
    logic               window_started;
    logic [TALLY_W-1:0] request_tally;
    logic [TALLY_W-1:0] tool_tally;
  } entry_t;

  function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
    return (v == TALLY_MAX) ? v : v + TALLY_W'(1);
  endfunction

endpackage

// ----- hdl/client_fixed_window_rate_limiter.sv -----
// Top level: stream ports, configuration registers, read-modify-write pipeline.
// An accepted item is registered in the compute stage, then in the output register.
// One item per cycle is sustained while m_axis_tready is high; the state memory's
// single read and write port set that figure, with a one-entry forward path covering
// back-to-back slots. After reset a clearing pass writes every slot, with tready low.
// Configuration registers reset to 60000, 120 and 60.
module client_fixed_window_rate_limiter #(
  parameter int unsigned CLIENT_SLOTS = cfwrl_pkg::DEF_CLIENT_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cfwrl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cfwrl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // client_slot [5:0], now_ticks [37:6], zero pad [39:38]
  input  logic [cfwrl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // is_tool_call [0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // requests_in_window [15:0], tools_in_window [31:16]
  output logic [cfwrl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // allowed [0]
  output logic [0:0]                        m_axis_tuser
);
  import cfwrl_pkg::*;

  localparam int unsigned AW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks <= RST_WINDOW_TICKS;
      cfg_q.request_cap  <= RST_REQUEST_CAP;
      cfg_q.tool_cap     <= RST_TOOL_CAP;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_TICKS: cfg_q.window_ticks <= cfg_data_i[TICK_W-1:0];
        REG_REQUEST_CAP:  cfg_q.request_cap  <= cfg_data_i[TALLY_W-1:0];
        REG_TOOL_CAP:     cfg_q.tool_cap     <= cfg_data_i[TALLY_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SLOT_W-1:0] in_slot;
  logic [TICK_W-1:0] in_now;
  logic              in_range;
  logic [AW-1:0]     in_addr;
  logic              acc;
  logic              clr_busy;

  assign in_slot  = s_axis_tdata[SLOT_W-1:0];
  assign in_now   = s_axis_tdata[SLOT_W +: TICK_W];
  assign in_range = {26'd0, in_slot} < 32'(CLIENT_SLOTS);

  if (AW <= SLOT_W) begin : g_addr_trunc
    assign in_addr = in_slot[AW-1:0];
  end else begin : g_addr_ext
    assign in_addr = {{(AW-SLOT_W){1'b0}}, in_slot};
  end

  logic              s1_valid_q, s1_valid_d;
  logic              s1_tool_q, s1_inr_q;
  logic [TICK_W-1:0] s1_now_q;
  logic [AW-1:0]     s1_addr_q;
  logic              s1_go;
  logic              m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic              m_allowed_q;

  assign s1_go         = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy && (!s1_valid_q || s1_go);
  assign acc           = s_axis_tvalid && s_axis_tready;

  entry_t        rd_entry, cur_entry, new_entry;
  entry_t        fwd_entry_q;
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic          item_we;
  logic          allowed;

  assign item_we = s1_go && s1_inr_q;

  cfwrl_table #(
    .CLIENT_SLOTS(CLIENT_SLOTS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (acc),
    .rd_addr_i  (in_addr),
    .rd_data_o  (rd_entry),
    .wr_en_i    (item_we),
    .wr_addr_i  (s1_addr_q),
    .wr_data_i  (new_entry),
    .clr_busy_o (clr_busy)
  );

  assign cur_entry = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_entry_q : rd_entry;

  cfwrl_decide u_decide (
    .cfg_i     (cfg_q),
    .entry_i   (cur_entry),
    .tool_i    (s1_tool_q),
    .now_i     (s1_now_q),
    .entry_o   (new_entry),
    .allowed_o (allowed)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (s1_go) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      if (item_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_tool_q <= s_axis_tuser[0];
      s1_now_q  <= in_now;
      s1_addr_q <= in_addr;
      s1_inr_q  <= in_range;
    end
    if (item_we) begin
      fwd_addr_q  <= s1_addr_q;
      fwd_entry_q <= new_entry;
    end
    if (s1_go) begin
      if (s1_inr_q) begin
        m_allowed_q <= allowed;
        m_data_q    <= {new_entry.tool_tally, new_entry.request_tally};
      end else begin
        m_allowed_q <= 1'b0;
        m_data_q    <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_allowed_q;

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !item_we)
    else $error("item write during clearing pass");

  a_admit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[TALLY_W-1:0] != '0))
    else $error("admitted item with zero request count");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_addr_q) && $stable(s1_now_q)))
    else $error("stalled item lost in compute stage");

endmodule

// ----- hdl/cfwrl_table.sv -----
// Per-client state memory with a registered read port and a clearing pass after reset.
module cfwrl_table #(
  parameter int unsigned CLIENT_SLOTS = cfwrl_pkg::DEF_CLIENT_SLOTS,
  localparam int unsigned AW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output cfwrl_pkg::entry_t  rd_data_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  cfwrl_pkg::entry_t  wr_data_i,
  output logic               clr_busy_o
);
  import cfwrl_pkg::*;

  entry_t        mem [CLIENT_SLOTS];
  entry_t        rd_data_q;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_busy_q, clr_busy_d;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(CLIENT_SLOTS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  assign we    = clr_busy_q || wr_en_i;
  assign waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
  assign wdata = clr_busy_q ? entry_t'('0) : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ----- hdl/cfwrl_decide.sv -----
// Window restart, admission check and tally update for one client entry.
module cfwrl_decide (
  input  cfwrl_pkg::cfg_t              cfg_i,
  input  cfwrl_pkg::entry_t            entry_i,
  input  logic                         tool_i,
  input  logic [cfwrl_pkg::TICK_W-1:0] now_i,
  output cfwrl_pkg::entry_t            entry_o,
  output logic                         allowed_o
);
  import cfwrl_pkg::*;

  logic [TICK_W-1:0]  elapsed;
  logic               restart;
  logic [TALLY_W-1:0] req_cur, tool_cur;
  logic               refuse;

  always_comb begin
    elapsed  = now_i - entry_i.window_begin;
    restart  = !entry_i.window_started || (elapsed >= cfg_i.window_ticks);
    req_cur  = restart ? '0 : entry_i.request_tally;
    tool_cur = restart ? '0 : entry_i.tool_tally;
    refuse   = ((cfg_i.request_cap != '0) && (req_cur >= cfg_i.request_cap)) ||
               (tool_i && (cfg_i.tool_cap != '0) && (tool_cur >= cfg_i.tool_cap));

    entry_o.window_begin   = restart ? now_i : entry_i.window_begin;
    entry_o.window_started = 1'b1;
    entry_o.request_tally  = refuse ? req_cur : bump(req_cur);
    entry_o.tool_tally     = (refuse || !tool_i) ? tool_cur : bump(tool_cur);
    allowed_o              = !refuse;
  end

endmodule
